// ----- hdl/pursuit_arc_curvature_defines.svh -----
// Assertion helpers shared by the arc curvature block.
`ifndef PURSUIT_ARC_CURVATURE_DEFINES_SVH
`define PURSUIT_ARC_CURVATURE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PAC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pursuit_arc_curvature: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pursuit_arc_curvature: check failed");

`endif

// ----- hdl/pac_pkg.sv -----
package pac_pkg;

    localparam int POS_WIDTH    = 24;
    localparam int HEAD_WIDTH   = 16;
    localparam int CURV_WIDTH   = 32;
    localparam int DIFF_WIDTH   = POS_WIDTH + 1;
    localparam int TRIG_WIDTH   = 26;
    localparam int ANGLE_WIDTH  = 29;
    localparam int Z_WIDTH      = 28;
    localparam int XY_WIDTH     = 27;
    localparam int ATAN_ENTRIES = 24;
    localparam int QUOT_WIDTH   = CURV_WIDTH + 1;

    localparam logic signed [ANGLE_WIDTH-1:0] PI_Q24      = 29'sd52707179;
    localparam logic signed [ANGLE_WIDTH-1:0] TWO_PI_Q24  = 29'sd105414358;
    localparam logic signed [ANGLE_WIDTH-1:0] HALF_PI_Q24 = 29'sd26353589;
    localparam logic signed [XY_WIDTH-1:0]    GAIN_Q24    = 27'sd10188014;
    localparam logic signed [XY_WIDTH-1:0]    ONE_Q24     = 27'sd16777216;

    localparam logic [CURV_WIDTH-1:0] CURV_MAX = 32'h7FFF_FFFF;
    localparam logic [CURV_WIDTH-1:0] CURV_MIN = 32'h8000_0000;

    localparam logic [23:0] ATAN_Q24 [ATAN_ENTRIES] = '{
        24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214, 24'd524117,
        24'd262123,   24'd131069,  24'd65536,   24'd32768,   24'd16384,   24'd8192,
        24'd4096,     24'd2048,    24'd1024,    24'd512,     24'd256,     24'd128,
        24'd64,       24'd32,      24'd16,      24'd8,       24'd4,       24'd2
    };

    typedef struct packed {
        logic signed [POS_WIDTH-1:0]  robot_x;
        logic signed [POS_WIDTH-1:0]  robot_y;
        logic signed [HEAD_WIDTH-1:0] robot_heading;
        logic signed [POS_WIDTH-1:0]  target_x;
        logic signed [POS_WIDTH-1:0]  target_y;
    } pose_t;

    typedef struct packed {
        logic signed [CURV_WIDTH-1:0] curvature;
        logic                         no_distance;
        logic                         saturated;
    } arc_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } div_meta_t;

    function automatic int cordic_iters(int steps);
        return (steps < ATAN_ENTRIES) ? steps : ATAN_ENTRIES;
    endfunction

    // wrap, fold, one stage per iteration, sign/clamp
    function automatic int cordic_latency(int steps);
        return cordic_iters(steps) + 3;
    endfunction

endpackage

// ----- hdl/pac_cordic.sv -----
module pac_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  logic                                   in_valid,
    input  logic signed [pac_pkg::HEAD_WIDTH-1:0]  heading,
    output logic                                   out_valid,
    output logic signed [pac_pkg::TRIG_WIDTH-1:0]  sin_q,
    output logic signed [pac_pkg::TRIG_WIDTH-1:0]  cos_q
);
    import pac_pkg::*;

    localparam int NIT = cordic_iters(CORDIC_STEPS);

    logic signed [ANGLE_WIDTH-1:0] a_in;
    logic signed [ANGLE_WIDTH-1:0] wrap_next;
    logic signed [ANGLE_WIDTH-1:0] wrap_reg;
    logic                          wv_reg;
    logic signed [ANGLE_WIDTH-1:0] fold_next;
    logic                          flip_next;

    logic signed [XY_WIDTH-1:0] x_reg [NIT+1];
    logic signed [XY_WIDTH-1:0] y_reg [NIT+1];
    logic signed [Z_WIDTH-1:0]  z_reg [NIT+1];
    logic                       f_reg [NIT+1];
    logic                       v_reg [NIT+1];

    logic signed [XY_WIDTH-1:0]   xf, yf;
    logic signed [TRIG_WIDTH-1:0] sin_next, cos_next;
    logic signed [TRIG_WIDTH-1:0] sin_reg, cos_reg;
    logic                         ov_reg;

    function automatic logic signed [TRIG_WIDTH-1:0] clamp_unit(
        input logic signed [XY_WIDTH-1:0] v);
        if (v > ONE_Q24)
            return TRIG_WIDTH'(ONE_Q24);
        else if (v < -ONE_Q24)
            return TRIG_WIDTH'(-ONE_Q24);
        else
            return TRIG_WIDTH'(v);
    endfunction

    // heading * 4096 in Q.24, one wrap by a full turn is always enough
    assign a_in = {{(ANGLE_WIDTH-HEAD_WIDTH-12){heading[HEAD_WIDTH-1]}}, heading, 12'b0};

    always_comb
    begin
        priority if (a_in > PI_Q24)
            wrap_next = a_in - TWO_PI_Q24;
        else if (a_in <= -PI_Q24)
            wrap_next = a_in + TWO_PI_Q24;
        else
            wrap_next = a_in;
    end

    always_comb
    begin
        flip_next = 1'b1;
        priority if (wrap_reg > HALF_PI_Q24)
            fold_next = wrap_reg - PI_Q24;
        else if (wrap_reg < -HALF_PI_Q24)
            fold_next = wrap_reg + PI_Q24;
        else
        begin
            fold_next = wrap_reg;
            flip_next = 1'b0;
        end
    end

    assign xf       = f_reg[NIT] ? -x_reg[NIT] : x_reg[NIT];
    assign yf       = f_reg[NIT] ? -y_reg[NIT] : y_reg[NIT];
    assign sin_next = clamp_unit(yf);
    assign cos_next = clamp_unit(xf);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg <= 1'b0;
            for (int i = 0; i <= NIT; i++)
                v_reg[i] <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            wv_reg   <= in_valid;
            v_reg[0] <= wv_reg;
            for (int i = 0; i < NIT; i++)
                v_reg[i+1] <= v_reg[i];
            ov_reg <= v_reg[NIT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wrap_reg <= wrap_next;
            x_reg[0] <= GAIN_Q24;
            y_reg[0] <= '0;
            z_reg[0] <= Z_WIDTH'(fold_next);
            f_reg[0] <= flip_next;
            // advance one rotation per stage
            for (int i = 0; i < NIT; i++)
            begin
                if (!z_reg[i][Z_WIDTH-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed(Z_WIDTH'(ATAN_Q24[i]));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed(Z_WIDTH'(ATAN_Q24[i]));
                end
                f_reg[i+1] <= f_reg[i];
            end
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign out_valid = ov_reg;
    assign sin_q     = sin_reg;
    assign cos_q     = cos_reg;

endmodule

// ----- hdl/pac_divider.sv -----
module pac_divider #(
    parameter int MAG_WIDTH = 53,
    parameter int DEN_WIDTH = 49
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic [MAG_WIDTH-1:0]               mag,
    input  logic [DEN_WIDTH-1:0]               den,
    input  pac_pkg::div_meta_t                 meta,
    output logic                               out_valid,
    output logic [pac_pkg::QUOT_WIDTH-1:0]     quot,
    output pac_pkg::div_meta_t                 meta_out
);
    import pac_pkg::*;

    localparam int NB = QUOT_WIDTH;
    localparam int CW = (MAG_WIDTH > DEN_WIDTH) ? MAG_WIDTH : DEN_WIDTH;

    logic [MAG_WIDTH-1:0]  rem_reg [NB+1];
    logic [DEN_WIDTH-1:0]  den_reg [NB+1];
    logic [NB-1:0]         q_reg   [NB+1];
    div_meta_t             m_reg   [NB+1];
    logic                  v_reg   [NB+1];
    logic [NB-1:0]         ge;

    // stage j settles quotient bit NB-1-j: does den << bit fit in the remainder
    always_comb
    begin
        for (int j = 0; j < NB; j++)
            ge[j] = CW'(rem_reg[j] >> (NB-1-j)) >= CW'(den_reg[j]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= NB; j++)
                v_reg[j] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int j = 0; j < NB; j++)
                v_reg[j+1] <= v_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= mag;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            m_reg[0]   <= meta;
            for (int j = 0; j < NB; j++)
            begin
                rem_reg[j+1] <= ge[j]
                    ? rem_reg[j] - (MAG_WIDTH'(den_reg[j]) << (NB-1-j))
                    : rem_reg[j];
                den_reg[j+1] <= den_reg[j];
                q_reg[j+1]   <= q_reg[j] | (NB'(ge[j]) << (NB-1-j));
                m_reg[j+1]   <= m_reg[j];
            end
        end
    end

    assign out_valid = v_reg[NB];
    assign quot      = q_reg[NB];
    assign meta_out  = m_reg[NB];

endmodule

// ----- hdl/pursuit_arc_curvature.sv -----
// Channel  Dir  Payload  Handshake
// pose     in   pose_t   pose_valid / pose_ready
// arc      out  arc_t    arc_valid  / arc_ready
//
// One pose enters per cycle while the pipe advances. Each result passes through
// wrap, fold, one CORDIC stage per step (at most 24), sign/clamp, products, sum,
// divider input register, 33 restoring divider stages and the output register.
// rst_n clears only the valid bits of every stage.
// All stages share one advance enable: the whole pipe holds while the output
// register is full and arc_ready is low, so nothing is dropped or repeated.
module pursuit_arc_curvature #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pose_valid,
    output logic            pose_ready,
    input  pac_pkg::pose_t  pose,
    output logic            arc_valid,
    input  logic            arc_ready,
    output pac_pkg::arc_t   arc
);
    import pac_pkg::*;

    `include "pursuit_arc_curvature_defines.svh"

    localparam int CLAT   = cordic_latency(CORDIC_STEPS);
    localparam int PROD_W = TRIG_WIDTH + DIFF_WIDTH;
    localparam int N_W    = PROD_W + 1;
    localparam int MAG_W  = N_W + 1;
    localparam int SQ_W   = 2 * POS_WIDTH;
    localparam int DEN_W  = SQ_W + 1;

    logic adv;

    // target minus robot, carried alongside the CORDIC
    logic signed [DIFF_WIDTH-1:0] dx_in, dy_in;
    logic signed [DIFF_WIDTH-1:0] dx_reg [CLAT];
    logic signed [DIFF_WIDTH-1:0] dy_reg [CLAT];

    logic                         cv;
    logic signed [TRIG_WIDTH-1:0] sin_q, cos_q;

    logic [POS_WIDTH-1:0]     adx, ady;
    logic                     mv_reg;
    logic signed [PROD_W-1:0] ps_reg, pc_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic                     mz_reg;

    logic                     nv_reg;
    logic signed [N_W-1:0]    n_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     nz_reg;

    logic [N_W-1:0]           n_abs;
    logic [MAG_W-1:0]         mag;
    div_meta_t                dmeta, dmeta_out;
    logic                     dv;
    logic [QUOT_WIDTH-1:0]    quot;

    arc_t                     arc_next;
    arc_t                     arc_reg;
    logic                     arc_valid_reg;

    // hold everything while the output register is full and not taken
    assign adv        = !arc_valid_reg || arc_ready;
    assign pose_ready = adv;

    assign dx_in = DIFF_WIDTH'(pose.target_x) - DIFF_WIDTH'(pose.robot_x);
    assign dy_in = DIFF_WIDTH'(pose.target_y) - DIFF_WIDTH'(pose.robot_y);

    pac_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pose_valid),
        .heading   (pose.robot_heading),
        .out_valid (cv),
        .sin_q     (sin_q),
        .cos_q     (cos_q)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg[0] <= dx_in;
            dy_reg[0] <= dy_in;
            for (int i = 1; i < CLAT; i++)
            begin
                dx_reg[i] <= dx_reg[i-1];
                dy_reg[i] <= dy_reg[i-1];
            end
        end
    end

    // differences never reach the full POS_WIDTH+1 range, so magnitudes fit POS_WIDTH
    assign adx = dx_reg[CLAT-1][DIFF_WIDTH-1] ? POS_WIDTH'(-dx_reg[CLAT-1])
                                               : POS_WIDTH'(dx_reg[CLAT-1]);
    assign ady = dy_reg[CLAT-1][DIFF_WIDTH-1] ? POS_WIDTH'(-dy_reg[CLAT-1])
                                               : POS_WIDTH'(dy_reg[CLAT-1]);

    // numerator 2*|S*dx - C*dy|, sign travels separately
    assign n_abs      = n_reg[N_W-1] ? N_W'(-n_reg) : N_W'(n_reg);
    assign mag        = {n_abs, 1'b0};
    assign dmeta.neg  = n_reg[N_W-1];
    assign dmeta.zero = nz_reg;

    pac_divider #(
        .MAG_WIDTH (MAG_W),
        .DEN_WIDTH (DEN_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (nv_reg),
        .mag       (mag),
        .den       (den_reg),
        .meta      (dmeta),
        .out_valid (dv),
        .quot      (quot),
        .meta_out  (dmeta_out)
    );

    // saturate to the 32-bit range; coincident points override everything
    always_comb
    begin
        arc_next.no_distance = 1'b0;
        arc_next.saturated   = 1'b0;
        if (dmeta_out.zero)
        begin
            arc_next.curvature   = '0;
            arc_next.no_distance = 1'b1;
        end
        else if (!dmeta_out.neg)
        begin
            if (quot[QUOT_WIDTH-1] || quot[CURV_WIDTH-1])
            begin
                arc_next.curvature = CURV_MAX;
                arc_next.saturated = 1'b1;
            end
            else
                arc_next.curvature = quot[CURV_WIDTH-1:0];
        end
        else
        begin
            if (quot[QUOT_WIDTH-1] || (quot[CURV_WIDTH-1] && (|quot[CURV_WIDTH-2:0])))
            begin
                arc_next.curvature = CURV_MIN;
                arc_next.saturated = 1'b1;
            end
            else
                arc_next.curvature = -quot[CURV_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg        <= 1'b0;
            nv_reg        <= 1'b0;
            arc_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mv_reg        <= cv;
            nv_reg        <= mv_reg;
            arc_valid_reg <= dv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // products, one register after each multiply
            ps_reg  <= PROD_W'(sin_q) * PROD_W'(dx_reg[CLAT-1]);
            pc_reg  <= PROD_W'(cos_q) * PROD_W'(dy_reg[CLAT-1]);
            sqx_reg <= SQ_W'(adx) * SQ_W'(adx);
            sqy_reg <= SQ_W'(ady) * SQ_W'(ady);
            mz_reg  <= (dx_reg[CLAT-1] == '0) && (dy_reg[CLAT-1] == '0);
            // combine
            n_reg   <= N_W'(ps_reg) - N_W'(pc_reg);
            den_reg <= DEN_W'(sqx_reg) + DEN_W'(sqy_reg);
            nz_reg  <= mz_reg;
            arc_reg <= arc_next;
        end
    end

    assign arc_valid = arc_valid_reg;
    assign arc       = arc_reg;

    `PAC_ASSERT_IMPL(a_zero_result, arc_valid && arc.no_distance,
        arc.curvature == '0 && !arc.saturated)
    `PAC_ASSERT_IMPL(a_sat_limit, arc_valid && arc.saturated,
        arc.curvature == CURV_MAX || arc.curvature == CURV_MIN)
    `PAC_ASSERT_IMPL(a_stall_only_full, !pose_ready, arc_valid && !arc_ready)
    `PAC_ASSERT_NEXT(a_hold_on_stall, arc_valid && !arc_ready, arc_valid && $stable(arc))

endmodule

// ----- verif/tb_pursuit_arc_curvature.sv -----
module tb_pursuit_arc_curvature;
    timeunit 1ns;
    timeprecision 1ps;

    import pac_pkg::*;

    localparam int STEPS       = 16;
    localparam int LATENCY     = STEPS + 40;
    localparam int IDLE_LIMIT  = 20000;
    localparam int RANDOM_POSES = 950;

    localparam longint PI_L   = 64'sd52707179;
    localparam longint HALF_L = 64'sd26353589;
    localparam longint GAIN_L = 64'sd10188014;
    localparam longint ONE_L  = 64'sd16777216;

    logic   clk;
    logic   rst_n;
    logic   pose_valid;
    logic   pose_ready;
    pose_t  pose;
    logic   arc_valid;
    logic   arc_ready;
    arc_t   arc;

    pose_t  pending_poses[$];
    arc_t   expected_arcs[$];
    int     error_count;
    int     idle_cycles;
    bit     pose_taken;    // the pose on the bus transferred at the last rising edge
    bit     quiet_sender;  // long stretch with no idling on either side
    bit     hold_sender;   // sender pauses until the pipe drains

    pursuit_arc_curvature #(.CORDIC_STEPS(STEPS)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .pose_valid (pose_valid),
        .pose_ready (pose_ready),
        .pose       (pose),
        .arc_valid  (arc_valid),
        .arc_ready  (arc_ready),
        .arc        (arc)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Arithmetic shift on a signed value rounds toward minus infinity.
    function automatic longint atan_step(int i);
        return longint'(ATAN_Q24[i]);
    endfunction

    // Rotation-mode CORDIC after wrapping the heading into (-pi, pi] and
    // folding it into [-pi/2, pi/2]; the fold negates both outputs.
    function automatic void heading_sin_cos(input logic signed [15:0] heading,
                                            output longint s, output longint c);
        longint a;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        bit     flip;
        a = longint'(heading) * 4096;
        x = GAIN_L;
        y = 0;
        flip = 1'b0;
        while (a > PI_L) a -= 2 * PI_L;
        while (a <= -PI_L) a += 2 * PI_L;
        if (a > HALF_L)
        begin
            a -= PI_L;
            flip = 1'b1;
        end
        else if (a < -HALF_L)
        begin
            a += PI_L;
            flip = 1'b1;
        end
        z = a;
        for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= atan_step(i);
            end
            else
            begin
                x += ys;
                y -= xs;
                z += atan_step(i);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = (y > ONE_L) ? ONE_L : (y < -ONE_L) ? -ONE_L : y;
        c = (x > ONE_L) ? ONE_L : (x < -ONE_L) ? -ONE_L : x;
    endfunction

    // Curvature = 2*(S*dx - C*dy)/(dx^2 + dy^2), truncated, saturated.
    function automatic arc_t arc_of_pose(pose_t p);
        arc_t    r;
        longint  dx;
        longint  dy;
        longint  s;
        longint  c;
        longint  n;
        logic [64:0] den;
        logic [64:0] mag;
        logic [64:0] q;
        dx = longint'(p.target_x) - longint'(p.robot_x);
        dy = longint'(p.target_y) - longint'(p.robot_y);
        r = '0;
        if (dx == 0 && dy == 0)
        begin
            r.no_distance = 1'b1;
            return r;
        end
        heading_sin_cos(p.robot_heading, s, c);
        n = s * dx - c * dy;
        den = 65'(dx * dx) + 65'(dy * dy);
        mag = 65'((n < 0) ? -n : n) * 2;
        q = den[64] ? 65'd0 : mag / den;
        if (n >= 0)
        begin
            if (q > 65'h7FFF_FFFF)
            begin
                q = 65'h7FFF_FFFF;
                r.saturated = 1'b1;
            end
            r.curvature = q[31:0];
        end
        else
        begin
            if (q > 65'h8000_0000)
            begin
                q = 65'h8000_0000;
                r.saturated = 1'b1;
            end
            r.curvature = 32'(0) - q[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic logic [23:0] random_position(bit near);
        if (near)
            return 24'($signed($urandom_range(0, 4000)) - 2000);
        return 24'($urandom);
    endfunction

    function automatic pose_t random_pose();
        pose_t p;
        int    mode;
        mode = $urandom_range(0, 9);
        p.robot_x = random_position(mode < 6);
        p.robot_y = random_position(mode < 6);
        p.robot_heading = 16'($urandom);
        if (mode == 9)
        begin
            // coincident points
            p.target_x = p.robot_x;
            p.target_y = p.robot_y;
        end
        else if (mode == 8)
        begin
            // target very close: large curvature
            p.target_x = p.robot_x + 24'($signed($urandom_range(0, 6)) - 3);
            p.target_y = p.robot_y + 24'($signed($urandom_range(0, 6)) - 3);
        end
        else
        begin
            p.target_x = random_position(mode < 6);
            p.target_y = random_position(mode < 6);
        end
        return p;
    endfunction

    function automatic pose_t make_pose(logic [23:0] rx, logic [23:0] ry,
                                        logic [15:0] h, logic [23:0] tx, logic [23:0] ty);
        pose_t p;
        p.robot_x = rx;
        p.robot_y = ry;
        p.robot_heading = h;
        p.target_x = tx;
        p.target_y = ty;
        return p;
    endfunction

    // Driver: present the next pending pose at the falling edge; hold it until
    // the transfer is seen at a rising edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!pose_valid || pose_taken)
            begin
                if (pending_poses.size() > 0 && !hold_sender
                    && (quiet_sender || $urandom_range(0, 99) >= 14))
                begin
                    pose       <= pending_poses.pop_front();
                    pose_valid <= 1'b1;
                end
                else
                    pose_valid <= 1'b0;
            end
            arc_ready <= quiet_sender || ($urandom_range(0, 99) >= 14);
        end
    end

    // Monitor: record each pose transfer as an expectation, check each arc
    // transfer against the oldest one, and watch for a stalled pipe.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            pose_taken <= pose_valid && pose_ready;
            if ((pose_valid && pose_ready) || (arc_valid && arc_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (pose_valid && pose_ready)
                expected_arcs.push_back(arc_of_pose(pose));
            if (arc_valid && arc_ready)
            begin
                if (expected_arcs.size() == 0)
                begin
                    $display("unexpected arc transfer at %0t", $realtime);
                    error_count++;
                end
                else
                begin
                    arc_t want;
                    want = expected_arcs.pop_front();
                    if (arc.curvature !== want.curvature)
                        report_mismatch("curvature", arc.curvature, want.curvature);
                    if (arc.no_distance !== want.no_distance)
                        report_mismatch("no_distance", arc.no_distance, want.no_distance);
                    if (arc.saturated !== want.saturated)
                        report_mismatch("saturated", arc.saturated, want.saturated);
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** pursuit_arc_curvature: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        pose_valid = 1'b0;
        arc_ready = 1'b0;
        pose = '0;
        error_count = 0;
        idle_cycles = 0;
        pose_taken = 1'b0;
        quiet_sender = 1'b0;
        hold_sender = 1'b0;

        // Directed poses: field extremes, every heading quadrant and wrap,
        // coincident points, target on the heading line.
        pending_poses.push_back(make_pose(24'h0, 24'h0, 16'h0, 24'h0, 24'h0));
        pending_poses.push_back(make_pose(24'h7FFFFF, 24'h7FFFFF, 16'h7FFF,
                                          24'h7FFFFF, 24'h7FFFFF));
        pending_poses.push_back(make_pose(24'h800000, 24'h800000, 16'h8000,
                                          24'h7FFFFF, 24'h7FFFFF));
        pending_poses.push_back(make_pose(24'h7FFFFF, 24'h800000, 16'h7FFF,
                                          24'h800000, 24'h7FFFFF));
        pending_poses.push_back(make_pose(24'h0, 24'h0, 16'h0, 24'h100, 24'h0));
        pending_poses.push_back(make_pose(24'h0, 24'h0, 16'h0, 24'h0, 24'h100));
        pending_poses.push_back(make_pose(24'h0, 24'h0, 16'd6434, 24'h0, 24'h100));
        pending_poses.push_back(make_pose(24'h0, 24'h0, -16'sd6434, 24'h100, 24'h0));
        pending_poses.push_back(make_pose(24'h0, 24'h0, 16'd12868, 24'h1, 24'h1));
        pending_poses.push_back(make_pose(24'h0, 24'h0, -16'sd12868, 24'h1, 24'hFFFFFF));
        pending_poses.push_back(make_pose(24'h0, 24'h0, 16'd25736, 24'h0, 24'h1));
        pending_poses.push_back(make_pose(24'h0, 24'h0, 16'd9000, 24'h1, 24'h0));
        pending_poses.push_back(make_pose(24'h0, 24'h0, -16'sd9000, 24'h0, 24'hFFFFFF));
        pending_poses.push_back(make_pose(24'h10, 24'h20, 16'h0, 24'h11, 24'h20));
        pending_poses.push_back(make_pose(24'h10, 24'h20, 16'h0, 24'h10, 24'h21));
        pending_poses.push_back(make_pose(24'h10, 24'h20, 16'h0, 24'h10, 24'h1F));
        pending_poses.push_back(make_pose(24'h123456, 24'h654321, 16'h1234,
                                          24'h123456, 24'h654321));
        pending_poses.push_back(make_pose(24'h800000, 24'h0, 16'd3217, 24'h7FFFFF,
                                          24'h7FFFFF));
        pending_poses.push_back(make_pose(24'h5A5A5A, 24'hA5A5A5, 16'h5A5A,
                                          24'hA5A5A5, 24'h5A5A5A));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Let the directed poses drain, then pause the sender until every
        // expected arc has come back.
        wait (pending_poses.size() == 0);
        hold_sender = 1'b1;
        @(posedge clk);
        wait (!pose_valid && expected_arcs.size() == 0);
        repeat (LATENCY) @(posedge clk);
        hold_sender = 1'b0;

        for (int i = 0; i < RANDOM_POSES; i++)
            pending_poses.push_back(random_pose());

        // Run a stretch of the random part with no idling at all.
        wait (pending_poses.size() < RANDOM_POSES - 300);
        quiet_sender = 1'b1;
        wait (pending_poses.size() < RANDOM_POSES - 500);
        quiet_sender = 1'b0;

        wait (pending_poses.size() == 0);
        @(posedge clk);
        wait (!pose_valid);
        @(posedge clk);
        wait (expected_arcs.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (arc_valid)
        begin
            $display("extra arc pending after drain");
            error_count++;
        end

        if (error_count == 0)
            $display("** pursuit_arc_curvature: PASSED **");
        else
            $display("** pursuit_arc_curvature: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/pac_pkg.sv
hdl/pac_cordic.sv
hdl/pac_divider.sv
hdl/pursuit_arc_curvature.sv
verif/tb_pursuit_arc_curvature.sv
